>>> rtl/core/itr_pkg.sv
// itr_pkg: shared constants, types and helpers for the integer to text block
// no dependencies; compiled first

package itr_pkg;

    // width of the converted value and derived sizes
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);
    localparam int NCHUNK      = (VALUE_WIDTH + 7) / 8;
    localparam int PAD_W       = NCHUNK * 8;
    localparam int STEP_W      = $clog2(NCHUNK + 1);

    // radix choice codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // ascii codes
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h61;

    localparam logic [3:0] TEN = 4'd10;

    // request and response between sequencer and divider
    typedef struct packed {
        logic       start;
        logic [1:0] radix_sel;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } div_rsp_t;

    // digit value to lower-case ascii
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < TEN)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_A + {3'b000, d - TEN};
        end
        return c;
    endfunction

endpackage

>>> rtl/core/itr_in_if.sv
// itr_in_if: input channel carrying the value and the radix choice
// depends on nothing; valid/ready handshake

interface itr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number;
    logic [1:0]         radix_select;

    modport source (output valid, output number, output radix_select, input ready);
    modport sink   (input valid, input number, input radix_select, output ready);
endinterface

>>> rtl/core/itr_out_if.sv
// itr_out_if: output channel carrying one text character per beat
// depends on nothing; valid/ready handshake

interface itr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    logic       last_char;

    modport source (output valid, output char_out, output last_char, input ready);
    modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

>>> rtl/core/integer_to_text_radix.sv
// integer_to_text_radix: signed value to ascii text in radix 2, 8, 10 or 16
// depends on itr_pkg, itr_in_if, itr_out_if, itr_divider, itr_digit_store
//
//   channel   dir   fields                      beat
//   req       in    number[31:0], radix_select  one value to convert
//   text      out   char_out[6:0], last_char    one character, msd first
//
// each value is taken only while the block is idle. digits come from the
// shared divider least significant first: one cycle a digit for radix 2, 8
// and 16; for radix 10 each digit is formed by the eight-bit divide step
// over the bytes of the value. characters then leave from the digit store
// read port at one a cycle while the text channel is ready.
// reset clears the sequencer and the output valid register; a stalled text
// channel holds the sequencer in place without losing a character.

module integer_to_text_radix (
    input  logic        clk,
    input  logic        rst_n,
    itr_in_if.sink      req,
    itr_out_if.source   text
);

    localparam int VW = itr_pkg::VALUE_WIDTH;
    localparam int CW = itr_pkg::CNT_W;
    localparam int AW = itr_pkg::ADDR_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_DIVIDE = 3'd2;
    localparam logic [2:0] ST_LEAD   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [VW-1:0] quot_reg, quot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          start_reg, start_next;
    logic [1:0]    radix_reg, radix_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    char_reg, char_next;
    logic          last_reg, last_next;

    logic signed [63:0] ext;
    logic [VW-1:0]      value;
    logic               slot_free;
    logic [CW-1:0]      cnt_m1;

    itr_pkg::div_req_t  div_req;
    itr_pkg::div_rsp_t  div_rsp;
    logic [VW-1:0]      div_quot;
    logic [VW-1:0]      dividend;
    logic               chain;

    logic               wr_en;
    logic               rd_en;
    logic [3:0]         rd_data;

    // value of the configured width, sign-extended from the input field
    assign ext       = 64'(req.number);
    assign value     = ext[VW-1:0];
    assign slot_free = !out_valid_reg || text.ready;
    assign cnt_m1    = cnt_reg - 1'b1;

    // next digit is started as soon as the previous quotient arrives
    assign chain            = (state_reg == ST_DIVIDE) && div_rsp.done && (div_quot != '0);
    assign div_req.start    = start_reg || chain;
    assign div_req.radix_sel = radix_reg;
    assign dividend         = start_reg ? quot_reg : div_quot;
    assign wr_en            = (state_reg == ST_DIVIDE) && div_rsp.done;

    assign req.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        start_next     = 1'b0;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    radix_next = req.radix_select;
                    if (value == '0)
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        neg_next   = value[VW-1];
                        quot_next  = value[VW-1] ? (~value + 1'b1) : value;
                        cnt_next   = '0;
                        start_next = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itr_pkg::CHAR_ZERO;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (div_quot == '0)
                    begin
                        state_next = ST_LEAD;
                    end
                end
            end
            ST_LEAD:
            begin
                if (!neg_reg || slot_free)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_m1;
                    if (neg_reg)
                    begin
                        out_valid_next = 1'b1;
                        char_next      = itr_pkg::CHAR_MINUS;
                        last_next      = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itr_pkg::digit_char(rd_data);
                    last_next      = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        cnt_next = cnt_m1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    itr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (dividend),
        .rsp      (div_rsp),
        .quotient (div_quot)
    );

    itr_digit_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (div_rsp.digit),
        .rd_en   (rd_en),
        .rd_addr (cnt_m1[AW-1:0]),
        .rd_data (rd_data)
    );

    // output beat
    assign text.valid     = out_valid_reg;
    assign text.char_out  = char_reg;
    assign text.last_char = last_reg;

    // checks
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside the divide phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(VW))
        else $error("digit count beyond store depth");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.last_char) |-> (text.char_out != itr_pkg::CHAR_MINUS))
        else $error("sign flagged as final character");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start a conversion");

endmodule

>>> rtl/core/itr_divider.sv
// itr_divider: shared divide unit, one digit per request
// depends on itr_pkg; shift for radix 2/8/16, eight quotient bits a cycle for radix 10

module itr_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  itr_pkg::div_req_t                  req,
    input  logic [itr_pkg::VALUE_WIDTH-1:0]    dividend,
    output itr_pkg::div_rsp_t                  rsp,
    output logic [itr_pkg::VALUE_WIDTH-1:0]    quotient
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [itr_pkg::STEP_W-1:0] step_reg, step_next;
    logic [itr_pkg::PAD_W-1:0]  work_reg, work_next;
    logic [3:0]                 rem_reg, rem_next;

    logic [7:0]                 chunk;
    logic [7:0]                 qbits;
    logic [3:0]                 r;
    logic [4:0]                 t;
    logic [2:0]                 shamt;
    logic [itr_pkg::VALUE_WIDTH-1:0] low_mask;

    // shift amount for the power-of-two radices
    always_comb
    begin
        unique case (req.radix_sel)
            itr_pkg::RADIX_BIN: shamt = 3'd1;
            itr_pkg::RADIX_OCT: shamt = 3'd3;
            itr_pkg::RADIX_DEC: shamt = 3'd0;
            itr_pkg::RADIX_HEX: shamt = 3'd4;
            default:            shamt = 3'd0;
        endcase
        low_mask = ~({itr_pkg::VALUE_WIDTH{1'b1}} << shamt);
    end

    // restoring divide by ten over the top eight bits of the working word
    always_comb
    begin
        chunk = work_reg[itr_pkg::PAD_W-1 -: 8];
        r     = rem_reg;
        qbits = 8'd0;
        t     = 5'd0;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, chunk[i]};
            if (t >= {1'b0, itr_pkg::TEN})
            begin
                qbits[i] = 1'b1;
                r        = 4'(t - {1'b0, itr_pkg::TEN});
            end
            else
            begin
                r = t[3:0];
            end
        end
    end

    // next state of the unit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            if (req.radix_sel == itr_pkg::RADIX_DEC)
            begin
                busy_next = 1'b1;
                step_next = itr_pkg::STEP_W'(itr_pkg::NCHUNK);
                work_next = itr_pkg::PAD_W'(dividend);
                rem_next  = 4'd0;
            end
            else
            begin
                done_next = 1'b1;
                work_next = itr_pkg::PAD_W'(dividend >> shamt);
                rem_next  = 4'(dividend & low_mask);
            end
        end
        else if (busy_reg)
        begin
            work_next = (work_reg << 8) | itr_pkg::PAD_W'(qbits);
            rem_next  = r;
            step_next = step_reg - 1'b1;
            if (step_reg == itr_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.digit = rem_reg;
    assign quotient  = work_reg[itr_pkg::VALUE_WIDTH-1:0];

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still stepping");

    a_dec_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || (done_reg && $past(busy_reg))) |-> (rem_reg < itr_pkg::TEN))
        else $error("decimal remainder out of range");

endmodule

>>> rtl/core/itr_digit_store.sv
// itr_digit_store: small digit memory, one write and one registered read port
// depends on itr_pkg for depth and address width

module itr_digit_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [itr_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [3:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [itr_pkg::ADDR_W-1:0]  rd_addr,
    output logic [3:0]                  rd_data
);

    logic [3:0] mem [itr_pkg::VALUE_WIDTH];
    logic [3:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
